// ----- sv/boxds_pkg.sv -----
// Shared types, register codes and byte helpers for the box-average downscaler.
package boxds_pkg;

	localparam int PIX_W      = 8;
	localparam int LANES      = 8;
	localparam int WORD_W     = PIX_W * LANES;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int MODE_W     = 3;
	localparam int DIM_W      = 11;
	localparam int ROW_W      = 10;
	localparam int HOLD_N     = 3;
	localparam logic [DIM_W-1:0] ROWS_MAX = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_MODE   = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_H2   = 3'd0,
		MODE_V2   = 3'd1,
		MODE_HV2  = 3'd2,
		MODE_H4V2 = 3'd3,
		MODE_H4V4 = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		VF_1 = 2'd0,
		VF_2 = 2'd1,
		VF_4 = 2'd2
	} vfact_t;

	typedef enum logic [1:0] {
		HF_1 = 2'd0,
		HF_2 = 2'd1,
		HF_4 = 2'd2
	} hfact_t;

	typedef struct packed {
		vfact_t vf;
		hfact_t hf;
	} factors_t;

	// Control that every vertical lane sees for the word in flight.
	typedef struct packed {
		vfact_t     vf;
		logic [1:0] phase;
	} vctl_t;

	// Codes above the last mode fall back to halving both ways.
	function automatic factors_t decode_mode(input logic [MODE_W-1:0] m);
		factors_t f;
		case (m)
			MODE_H2: begin
				f.vf = VF_1;
				f.hf = HF_2;
			end
			MODE_V2: begin
				f.vf = VF_2;
				f.hf = HF_1;
			end
			MODE_H4V2: begin
				f.vf = VF_2;
				f.hf = HF_4;
			end
			MODE_H4V4: begin
				f.vf = VF_4;
				f.hf = HF_4;
			end
			default: begin
				f.vf = VF_2;
				f.hf = HF_2;
			end
		endcase
		return f;
	endfunction

	// Rounding average of two pixels.
	function automatic logic [PIX_W-1:0] avg_pix(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
		return s[PIX_W:1];
	endfunction

endpackage

// ----- sv/boxds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module boxds_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/boxds_vlane.sv -----
// One byte lane of the vertical reduction: pass-through, row-pair and row-quad averaging.
module boxds_vlane (
	input  boxds_pkg::vctl_t ctl,
	input  logic [7:0]       px,
	input  logic [7:0]       first,
	input  logic [7:0]       second,
	output logic [7:0]       v,
	output logic [7:0]       first_wr
);
	import boxds_pkg::*;

	logic [7:0] avg_fp;
	logic [7:0] avg_sp;

	assign avg_fp = avg_pix(first, px);
	assign avg_sp = avg_pix(second, px);

	// First row of a group is stored raw; the second row folds into it.
	assign first_wr = (ctl.phase == 2'd0) ? px : avg_fp;

	always_comb begin
		case (ctl.vf)
			VF_1:    v = px;
			VF_2:    v = avg_fp;
			VF_4:    v = avg_pix(first, avg_sp);
			default: v = avg_fp;
		endcase
	end

endmodule

// ----- sv/boxds_hmerge.sv -----
// Merges vertically reduced words into one output word by 2:1 or 4:1 box sums, or passes one word through.
module boxds_hmerge (
	input  boxds_pkg::hfact_t hf,
	input  logic [63:0]       hold0,
	input  logic [63:0]       hold1,
	input  logic [63:0]       hold2,
	input  logic [63:0]       v,
	output logic [63:0]       result
);
	import boxds_pkg::*;

	logic [63:0] grp [4];
	logic [63:0] res_h2;
	logic [63:0] res_h4;

	always_comb begin
		grp[0] = hold0;
		grp[1] = (hf == HF_2) ? v : hold1;
		grp[2] = hold2;
		grp[3] = v;
	end

	for (genvar m = 0; m < LANES; m++) begin : g_out
		localparam int W2 = m / 4;
		localparam int B2 = (2 * m) % 8;
		localparam int W4 = m / 2;
		localparam int B4 = (4 * m) % 8;
		logic [8:0] sum2;
		logic [9:0] sum4;

		assign sum2 = {1'b0, grp[W2][8*B2 +: 8]} + {1'b0, grp[W2][8*(B2+1) +: 8]};
		assign sum4 = {2'b00, grp[W4][8*B4 +: 8]} + {2'b00, grp[W4][8*(B4+1) +: 8]}
			+ {2'b00, grp[W4][8*(B4+2) +: 8]} + {2'b00, grp[W4][8*(B4+3) +: 8]};

		// The truncating shift already bounds each sum to one byte.
		assign res_h2[8*m +: 8] = sum2[8:1];
		assign res_h4[8*m +: 8] = sum4[9:2];
	end

	always_comb begin
		case (hf)
			HF_1:    result = v;
			HF_2:    result = res_h2;
			HF_4:    result = res_h4;
			default: result = res_h2;
		endcase
	end

endmodule

// ----- sv/box_average_image_downscaler_top.sv -----
// Top level of the box-average image downscaler: sequencing, line buffers, output stage.
//
// Source pixels arrive on s_axis as 64-bit words of eight 8-bit pixels, byte 0
// leftmost, in raster order. Downscaled words leave on m_axis with tlast set on
// the last word of a frame. Scale mode and image size are written on the cfg
// channel (index 0 mode, 1 width, 2 height); any known write restarts the frame.
// Write configuration only while no words are in flight.
//
// Throughput is one input word per clock while m_axis does not stall. The input
// transfer that completes a block produces its result on m_axis: the transfer
// loads the read stage together with the line buffer read data, and the vertical
// lanes and horizontal merge then feed the output register once it is free. Words
// that only fill a line buffer or the horizontal hold give no output. When m_axis
// stalls, one word waits in the output register and one in the read stage, and
// s_axis deasserts tready once both are full.
//
// Reset sets mode 2 (halve both ways), width 640, height 480, and clears the
// row and column counters and the horizontal hold. Line buffers are not
// cleared: every entry is written in a frame before its read data is used.
module box_average_image_downscaler_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [boxds_pkg::WORD_W-1:0]        s_axis_tdata,  // [63:0] pixels_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [boxds_pkg::WORD_W-1:0]        m_axis_tdata,  // [63:0] pixels_out
	output logic                                m_axis_tlast,  // frame_last
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [boxds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [boxds_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import boxds_pkg::*;

	localparam int WORDS_MAX = (MAX_WIDTH / 32) * 4;
	localparam int COL_W     = $clog2(WORDS_MAX);
	localparam int WPR_W     = $clog2(WORDS_MAX + 1);
	localparam int CMP_W     = (WPR_W > 8) ? WPR_W : 8;

	// Configuration
	logic [MODE_W-1:0] scale_mode_q;
	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic              cfg_xfer;
	logic              cfg_known;

	// Frame position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Read stage
	logic              valid_s1;
	logic [WORD_W-1:0] px_s1;
	logic [COL_W-1:0]  col_s1;
	logic [1:0]        phase_s1;
	logic              last_s1;

	// Output stage
	logic              out_valid_q;
	logic [WORD_W-1:0] out_data_q;
	logic              out_last_q;

	logic [WORD_W-1:0] hold_q [HOLD_N];

	factors_t         fac;
	logic [CMP_W-1:0] wpr_raw;
	logic [CMP_W-1:0] wpr_clamp;
	logic [WPR_W-1:0] wpr;
	logic [DIM_W-1:0] vmask;
	logic [DIM_W-1:0] vf_n;
	logic [DIM_W-1:0] rows_raw;
	logic [DIM_W-1:0] rows;
	logic [DIM_W-1:0] rows_m1;
	logic [1:0]       phase;
	logic             col_last;
	logic             row_last;
	logic             in_xfer;

	logic              out_free;
	logic              s1_ready;
	logic              s1_emit;
	logic              s1_leave;
	logic [1:0]        pos;
	logic              pos_last;
	vctl_t             vctl;
	logic [WORD_W-1:0] first_rd;
	logic [WORD_W-1:0] second_rd;
	logic [WORD_W-1:0] v_word;
	logic [WORD_W-1:0] first_wr;
	logic [WORD_W-1:0] h_result;
	logic              first_we;
	logic              second_we;

	assign fac = decode_mode(scale_mode_q);

	// Words per row: whole 32-pixel groups, four words each, clamped.
	always_comb begin
		wpr_raw = CMP_W'({image_width_q[DIM_W-1:5], 2'b00});
		if (wpr_raw < CMP_W'(4)) begin
			wpr_clamp = CMP_W'(4);
		end else if (wpr_raw > CMP_W'(WORDS_MAX)) begin
			wpr_clamp = CMP_W'(WORDS_MAX);
		end else begin
			wpr_clamp = wpr_raw;
		end
		wpr = WPR_W'(wpr_clamp);
	end

	// Rows per frame: whole vertical groups, clamped.
	always_comb begin
		case (fac.vf)
			VF_1: begin
				vmask = '1;
				vf_n  = DIM_W'(1);
			end
			VF_4: begin
				vmask = ~DIM_W'(3);
				vf_n  = DIM_W'(4);
			end
			default: begin
				vmask = ~DIM_W'(1);
				vf_n  = DIM_W'(2);
			end
		endcase
		rows_raw = image_height_q & vmask;
		if (rows_raw < vf_n) begin
			rows = vf_n;
		end else if (rows_raw > ROWS_MAX) begin
			rows = ROWS_MAX;
		end else begin
			rows = rows_raw;
		end
		rows_m1 = rows - DIM_W'(1);
	end

	always_comb begin
		case (fac.vf)
			VF_2:    phase = {1'b0, row_q[0]};
			VF_4:    phase = row_q[1:0];
			default: phase = 2'd0;
		endcase
	end

	assign col_last = (WPR_W'(col_q) == wpr - WPR_W'(1));
	assign row_last = ({1'b0, row_q} == rows_m1);

	// Handshakes
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_leave      = valid_s1 && (!s1_emit || out_free);
	assign s_axis_tready = !valid_s1 || s1_leave;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_xfer      = cfg_valid && cfg_ready;
	assign cfg_known     = (cfg_index == REG_SCALE_MODE) || (cfg_index == REG_IMAGE_WIDTH)
		|| (cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q   <= MODE_HV2;
			image_width_q  <= DIM_W'(640);
			image_height_q <= DIM_W'(480);
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_xfer && cfg_known) begin
			case (cfg_index)
				REG_SCALE_MODE:   scale_mode_q   <= cfg_data[MODE_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default:          scale_mode_q   <= scale_mode_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_s1    <= s_axis_tdata;
			col_s1   <= col_q;
			phase_s1 <= phase;
			last_s1  <= col_last && row_last;
		end
	end

	boxds_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS_MAX)
	) u_row_first (
		.clk     (clk),
		.wr_en   (first_we),
		.wr_addr (col_s1),
		.wr_data (first_wr),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (first_rd)
	);

	boxds_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS_MAX)
	) u_row_second (
		.clk     (clk),
		.wr_en   (second_we),
		.wr_addr (col_s1),
		.wr_data (px_s1),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (second_rd)
	);

	assign vctl.vf    = fac.vf;
	assign vctl.phase = phase_s1;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		boxds_vlane u_vlane (
			.ctl      (vctl),
			.px       (px_s1[PIX_W*i +: PIX_W]),
			.first    (first_rd[PIX_W*i +: PIX_W]),
			.second   (second_rd[PIX_W*i +: PIX_W]),
			.v        (v_word[PIX_W*i +: PIX_W]),
			.first_wr (first_wr[PIX_W*i +: PIX_W])
		);
	end

	boxds_hmerge u_hmerge (
		.hf     (fac.hf),
		.hold0  (hold_q[0]),
		.hold1  (hold_q[1]),
		.hold2  (hold_q[2]),
		.v      (v_word),
		.result (h_result)
	);

	// Vertical group complete on its last row; horizontal group on its last word.
	always_comb begin
		case (fac.vf)
			VF_1:    s1_ready = 1'b1;
			VF_4:    s1_ready = (phase_s1 == 2'd3);
			default: s1_ready = (phase_s1 == 2'd1);
		endcase
		case (fac.hf)
			HF_1: begin
				pos      = 2'd0;
				pos_last = 1'b1;
			end
			HF_4: begin
				pos      = col_s1[1:0];
				pos_last = (col_s1[1:0] == 2'd3);
			end
			default: begin
				pos      = {1'b0, col_s1[0]};
				pos_last = col_s1[0];
			end
		endcase
		s1_emit   = s1_ready && pos_last;
		first_we  = s1_leave && (fac.vf != VF_1) && (phase_s1 == 2'd0
			|| (fac.vf == VF_4 && phase_s1 == 2'd1));
		second_we = s1_leave && (fac.vf == VF_4) && (phase_s1 == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HOLD_N; k++) begin
				hold_q[k] <= '0;
			end
		end else if (cfg_xfer && cfg_known) begin
			for (int k = 0; k < HOLD_N; k++) begin
				hold_q[k] <= '0;
			end
		end else if (s1_leave && s1_ready && !pos_last) begin
			hold_q[pos] <= v_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && s1_emit) begin
			out_data_q <= h_result;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule
